[rtl/blm_pkg.sv]
// Shared types, register map, reset values and classification helpers of the battery level monitor.
`default_nettype none
package blm_pkg;

	typedef enum logic [2:0] {
		LVL_INIT     = 3'd0,
		LVL_SETTLING = 3'd1,
		LVL_GOOD     = 3'd2,
		LVL_LOW      = 3'd3,
		LVL_CRITICAL = 3'd4,
		LVL_OVER     = 3'd5
	} level_t;

	localparam int unsigned MV_W     = 16;
	localparam int unsigned TICK_W   = 8;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned REG_IDX_W = 3;

	typedef logic [MV_W-1:0]   mv_t;
	typedef logic [TICK_W-1:0] tick_t;

	localparam logic [REG_IDX_W-1:0] REG_CRITICAL = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOW      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OVER     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HYST     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SETTLE   = 3'd4;

	localparam mv_t   CRITICAL_RST = 16'd20000;
	localparam mv_t   LOW_RST      = 16'd22000;
	localparam mv_t   OVER_RST     = 16'd29000;
	localparam mv_t   HYST_RST     = 16'd500;
	localparam tick_t SETTLE_RST   = 8'd30;

	typedef struct packed {
		mv_t critical;
		mv_t low;
		mv_t over;
	} thresholds_t;

	// Critical wins when the thresholds overlap.
	function automatic level_t classify(input mv_t v, input thresholds_t th);
		level_t res;
		if (v <= th.critical) begin
			res = LVL_CRITICAL;
		end else if (v >= th.over) begin
			res = LVL_OVER;
		end else if (v <= th.low) begin
			res = LVL_LOW;
		end else begin
			res = LVL_GOOD;
		end
		return res;
	endfunction

	function automatic mv_t plus_h(input mv_t v, input mv_t h);
		logic [MV_W:0] sum;
		sum = {1'b0, v} + {1'b0, h};
		return sum[MV_W] ? {MV_W{1'b1}} : sum[MV_W-1:0];
	endfunction

	function automatic mv_t minus_h(input mv_t v, input mv_t h);
		return (v > h) ? mv_t'(v - h) : '0;
	endfunction

endpackage
`default_nettype wire

[rtl/battery_level_monitor_top.sv]
// Battery level monitor: classifies each voltage request with hysteresis and raises off requests.
// A request is registered in the input register and its result is then registered in the result register.
// Throughput: one request per cycle unless the output stalls; the level state updates from the input register.
// Reset (arst_n low, asynchronous) returns the level to init, clears the settling count and the
// disabled flag, empties both pipeline registers and restores the default thresholds, hysteresis and settle time.
`default_nettype none
module battery_level_monitor_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [blm_pkg::MV_W-1:0]      voltage_mv,
	input  wire logic                          restart,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [2:0]                    level,
	output      logic                          charger_off_request,
	output      logic                          power_stage_off_request,
	output      logic                          device_disabled,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [blm_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [blm_pkg::DATA_W-1:0]    pwdata,
	output      logic [blm_pkg::DATA_W-1:0]    prdata,
	output      logic                          pready
);

	// Configuration registers
	blm_pkg::thresholds_t th_q;
	blm_pkg::mv_t         hyst_q;
	blm_pkg::tick_t       settle_ticks_q;

	logic [blm_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[blm_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_q.critical  <= blm_pkg::CRITICAL_RST;
			th_q.low       <= blm_pkg::LOW_RST;
			th_q.over      <= blm_pkg::OVER_RST;
			hyst_q         <= blm_pkg::HYST_RST;
			settle_ticks_q <= blm_pkg::SETTLE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				blm_pkg::REG_CRITICAL: th_q.critical  <= pwdata[blm_pkg::MV_W-1:0];
				blm_pkg::REG_LOW:      th_q.low       <= pwdata[blm_pkg::MV_W-1:0];
				blm_pkg::REG_OVER:     th_q.over      <= pwdata[blm_pkg::MV_W-1:0];
				blm_pkg::REG_HYST:     hyst_q         <= pwdata[blm_pkg::MV_W-1:0];
				blm_pkg::REG_SETTLE:   settle_ticks_q <= pwdata[blm_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			blm_pkg::REG_CRITICAL: prdata = {{(blm_pkg::DATA_W-blm_pkg::MV_W){1'b0}}, th_q.critical};
			blm_pkg::REG_LOW:      prdata = {{(blm_pkg::DATA_W-blm_pkg::MV_W){1'b0}}, th_q.low};
			blm_pkg::REG_OVER:     prdata = {{(blm_pkg::DATA_W-blm_pkg::MV_W){1'b0}}, th_q.over};
			blm_pkg::REG_HYST:     prdata = {{(blm_pkg::DATA_W-blm_pkg::MV_W){1'b0}}, hyst_q};
			blm_pkg::REG_SETTLE:   prdata = {{(blm_pkg::DATA_W-blm_pkg::TICK_W){1'b0}}, settle_ticks_q};
			default:               prdata = '0;
		endcase
	end

	// Input register and flow control
	logic          valid_s1;
	blm_pkg::mv_t  voltage_s1;
	logic          restart_s1;
	logic          adv;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			voltage_s1 <= voltage_mv;
			restart_s1 <= restart;
		end
	end

	// Level state
	blm_pkg::level_t cur_level_q, prev_level_q;
	blm_pkg::tick_t  settle_cnt_q;
	logic            disabled_q;

	blm_pkg::level_t cls_v, cls_plus, cls_minus;
	blm_pkg::level_t cur_next, prev_next;
	blm_pkg::tick_t  settle_next, settle_dec;
	logic            disabled_next, charger_off, stage_off;

	assign cls_v     = blm_pkg::classify(voltage_s1, th_q);
	assign cls_plus  = blm_pkg::classify(blm_pkg::plus_h(voltage_s1, hyst_q), th_q);
	assign cls_minus = blm_pkg::classify(blm_pkg::minus_h(voltage_s1, hyst_q), th_q);
	assign settle_dec = (settle_cnt_q != '0) ? blm_pkg::tick_t'(settle_cnt_q - 1'b1) : settle_cnt_q;

	always_comb begin
		cur_next      = cur_level_q;
		prev_next     = prev_level_q;
		settle_next   = settle_cnt_q;
		disabled_next = disabled_q;
		charger_off   = 1'b0;
		stage_off     = 1'b0;
		if (restart_s1) begin
			cur_next  = blm_pkg::LVL_INIT;
			prev_next = blm_pkg::LVL_INIT;
		end else begin
			case (cur_level_q)
				blm_pkg::LVL_INIT: begin
					settle_next = settle_ticks_q;
					cur_next    = blm_pkg::LVL_SETTLING;
				end
				blm_pkg::LVL_SETTLING: begin
					settle_next = settle_dec;
					if (settle_dec == '0) cur_next = cls_v;
				end
				blm_pkg::LVL_GOOD: begin
					// Entering low or overvoltage needs the margin to hold as well.
					if (cls_v == blm_pkg::LVL_LOW) begin
						if (cls_plus == blm_pkg::LVL_LOW) cur_next = blm_pkg::LVL_LOW;
					end else if (cls_v == blm_pkg::LVL_OVER) begin
						if (cls_minus == blm_pkg::LVL_OVER) cur_next = blm_pkg::LVL_OVER;
					end else begin
						cur_next = cls_v;
					end
				end
				blm_pkg::LVL_LOW: begin
					if (cls_v == blm_pkg::LVL_GOOD) begin
						if (cls_minus == blm_pkg::LVL_GOOD) cur_next = blm_pkg::LVL_GOOD;
					end else begin
						cur_next = cls_v;
					end
				end
				blm_pkg::LVL_CRITICAL: cur_next = cls_minus;
				blm_pkg::LVL_OVER:     cur_next = cls_plus;
				default: ;
			endcase

			if (cur_next == blm_pkg::LVL_OVER && prev_level_q != blm_pkg::LVL_OVER) begin
				charger_off = 1'b1;
			end
			if (cur_next == blm_pkg::LVL_CRITICAL) begin
				if (!disabled_q) begin
					stage_off     = 1'b1;
					charger_off   = 1'b1;
					disabled_next = 1'b1;
				end
			end else begin
				disabled_next = 1'b0;
			end
			prev_next = cur_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_level_q  <= blm_pkg::LVL_INIT;
			prev_level_q <= blm_pkg::LVL_INIT;
			settle_cnt_q <= '0;
			disabled_q   <= 1'b0;
		end else if (adv) begin
			cur_level_q  <= cur_next;
			prev_level_q <= prev_next;
			settle_cnt_q <= settle_next;
			disabled_q   <= disabled_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level                   <= cur_next;
			charger_off_request     <= charger_off;
			power_stage_off_request <= stage_off;
			device_disabled         <= disabled_next;
		end
	end

endmodule
`default_nettype wire

[sim/battery_level_monitor_tb.sv]
// Battery level monitor testbench: directed and random ticks, checked against a predictor or typed rows.
`timescale 1ns / 1ps
module testbench;

	localparam int unsigned CYCLE_LIMIT = 250000;
	localparam int unsigned PHASES = 8;

	typedef struct packed {
		blm_pkg::level_t lvl;
		logic   charger_off;
		logic   stage_off;
		logic   disabled;
	} monitor_result_t;

	typedef struct packed {
		blm_pkg::mv_t    volt;
		logic   rs;
		logic   typed;
		blm_pkg::level_t lvl;
		logic   chg;
		logic   stg;
		logic   dis;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	blm_pkg::mv_t voltage_mv = '0;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] level;
	logic charger_off_request;
	logic power_stage_off_request;
	logic device_disabled;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [blm_pkg::ADDR_W-1:0] paddr = '0;
	logic [blm_pkg::DATA_W-1:0] pwdata = '0;
	logic [blm_pkg::DATA_W-1:0] prdata;
	logic pready;

	battery_level_monitor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.voltage_mv(voltage_mv),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level(level),
		.charger_off_request(charger_off_request),
		.power_stage_off_request(power_stage_off_request),
		.device_disabled(device_disabled),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor copy of the configuration and the monitor state.
	blm_pkg::mv_t crit_mv = blm_pkg::CRITICAL_RST;
	blm_pkg::mv_t low_mv = blm_pkg::LOW_RST;
	blm_pkg::mv_t over_mv = blm_pkg::OVER_RST;
	blm_pkg::mv_t hyst_mv = blm_pkg::HYST_RST;
	blm_pkg::tick_t settle_cfg = blm_pkg::SETTLE_RST;
	blm_pkg::level_t cur_lvl = blm_pkg::LVL_INIT;
	blm_pkg::level_t prev_lvl = blm_pkg::LVL_INIT;
	blm_pkg::tick_t settle_cnt = '0;
	logic dis_flag = 1'b0;

	monitor_result_t pending_results[$];
	int unsigned err_count = 0;
	int unsigned results_checked = 0;
	int unsigned tick_count = 0;
	int unsigned restart_count = 0;
	int unsigned settings_count = 0;
	int unsigned cycle_count = 0;
	int unsigned tx_calm = 0;
	int unsigned rx_calm = 0;

	logic [blm_pkg::REG_IDX_W-1:0] all_regs[5] = '{blm_pkg::REG_CRITICAL, blm_pkg::REG_LOW,
		blm_pkg::REG_OVER, blm_pkg::REG_HYST, blm_pkg::REG_SETTLE};

	stim_row_t directed_rows[23] = '{
		'{16'd0,     1'b1, 1'b1, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd25000, 1'b0, 1'b1, blm_pkg::LVL_SETTLING, 1'b0, 1'b0, 1'b0},
		'{16'd25000, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd21800, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd21000, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd22300, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd23000, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd20000, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd20300, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd0,     1'b1, 1'b1, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b1},
		'{16'd0,     1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd0,     1'b0, 1'b1, blm_pkg::LVL_CRITICAL, 1'b1, 1'b1, 1'b1},
		'{16'd300,   1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd65535, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd65535, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd29000, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd28600, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd28400, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd29000, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd29600, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd0,     1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd30000, 1'b0, 1'b0, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0},
		'{16'd65535, 1'b1, 1'b1, blm_pkg::LVL_INIT,     1'b0, 1'b0, 1'b0}
	};

	// Critical takes priority when the thresholds overlap.
	function automatic blm_pkg::level_t grade_voltage(input blm_pkg::mv_t v);
		if (v <= crit_mv) return blm_pkg::LVL_CRITICAL;
		if (v >= over_mv) return blm_pkg::LVL_OVER;
		if (v <= low_mv) return blm_pkg::LVL_LOW;
		return blm_pkg::LVL_GOOD;
	endfunction

	function automatic blm_pkg::mv_t add_margin(input blm_pkg::mv_t v);
		int unsigned sum;
		sum = int'(v) + int'(hyst_mv);
		return (sum > 65535) ? 16'hFFFF : blm_pkg::mv_t'(sum);
	endfunction

	function automatic blm_pkg::mv_t sub_margin(input blm_pkg::mv_t v);
		return (v > hyst_mv) ? blm_pkg::mv_t'(v - hyst_mv) : '0;
	endfunction

	function automatic monitor_result_t advance_monitor(input blm_pkg::mv_t v, input logic rs);
		monitor_result_t r;
		blm_pkg::level_t c;
		r = '0;
		if (rs) begin
			cur_lvl = blm_pkg::LVL_INIT;
			prev_lvl = blm_pkg::LVL_INIT;
		end else begin
			case (cur_lvl)
				blm_pkg::LVL_INIT: begin
					settle_cnt = settle_cfg;
					cur_lvl = blm_pkg::LVL_SETTLING;
				end
				blm_pkg::LVL_SETTLING: begin
					if (settle_cnt != 0) settle_cnt = settle_cnt - 1'b1;
					if (settle_cnt == 0) cur_lvl = grade_voltage(v);
				end
				blm_pkg::LVL_GOOD: begin
					c = grade_voltage(v);
					if (c == blm_pkg::LVL_LOW) begin
						if (grade_voltage(add_margin(v)) == blm_pkg::LVL_LOW)
							cur_lvl = blm_pkg::LVL_LOW;
					end else if (c == blm_pkg::LVL_OVER) begin
						if (grade_voltage(sub_margin(v)) == blm_pkg::LVL_OVER)
							cur_lvl = blm_pkg::LVL_OVER;
					end else begin
						cur_lvl = c;
					end
				end
				blm_pkg::LVL_LOW: begin
					c = grade_voltage(v);
					if (c == blm_pkg::LVL_GOOD) begin
						if (grade_voltage(sub_margin(v)) == blm_pkg::LVL_GOOD)
							cur_lvl = blm_pkg::LVL_GOOD;
					end else begin
						cur_lvl = c;
					end
				end
				blm_pkg::LVL_CRITICAL: cur_lvl = grade_voltage(sub_margin(v));
				blm_pkg::LVL_OVER: cur_lvl = grade_voltage(add_margin(v));
				default: ;
			endcase
			if (cur_lvl == blm_pkg::LVL_OVER && prev_lvl != blm_pkg::LVL_OVER)
				r.charger_off = 1'b1;
			if (cur_lvl == blm_pkg::LVL_CRITICAL) begin
				if (!dis_flag) begin
					r.stage_off = 1'b1;
					r.charger_off = 1'b1;
					dis_flag = 1'b1;
				end
			end else begin
				dis_flag = 1'b0;
			end
			prev_lvl = cur_lvl;
		end
		r.lvl = cur_lvl;
		r.disabled = dis_flag;
		return r;
	endfunction

	function automatic logic [blm_pkg::DATA_W-1:0] register_image(
		input logic [blm_pkg::REG_IDX_W-1:0] idx);
		case (idx)
			blm_pkg::REG_CRITICAL: return blm_pkg::DATA_W'(crit_mv);
			blm_pkg::REG_LOW: return blm_pkg::DATA_W'(low_mv);
			blm_pkg::REG_OVER: return blm_pkg::DATA_W'(over_mv);
			blm_pkg::REG_HYST: return blm_pkg::DATA_W'(hyst_mv);
			blm_pkg::REG_SETTLE: return blm_pkg::DATA_W'(settle_cfg);
			default: return '0;
		endcase
	endfunction

	// Mostly random waits, with occasional stretches of back-to-back traffic.
	function automatic int unsigned pick_gap(ref int unsigned calm_left);
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	// Voltages cluster around the thresholds so that the hysteresis bands get exercised.
	function automatic blm_pkg::mv_t pick_voltage();
		int sel;
		int span;
		int t;
		blm_pkg::mv_t base;
		sel = $urandom_range(0, 19);
		if (sel < 12) begin
			case ($urandom_range(0, 2))
				0: base = crit_mv;
				1: base = low_mv;
				default: base = over_mv;
			endcase
			span = int'(hyst_mv) + 64;
			t = int'(base) + int'($urandom_range(0, 2 * span)) - span;
			if (t < 0) t = 0;
			if (t > 65535) t = 65535;
			return blm_pkg::mv_t'(t);
		end
		if (sel < 18) return blm_pkg::mv_t'($urandom);
		return (sel == 18) ? 16'd0 : 16'hFFFF;
	endfunction

	task automatic write_register(input logic [blm_pkg::REG_IDX_W-1:0] idx,
		input logic [blm_pkg::DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= blm_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			blm_pkg::REG_CRITICAL: crit_mv = value[blm_pkg::MV_W-1:0];
			blm_pkg::REG_LOW: low_mv = value[blm_pkg::MV_W-1:0];
			blm_pkg::REG_OVER: over_mv = value[blm_pkg::MV_W-1:0];
			blm_pkg::REG_HYST: hyst_mv = value[blm_pkg::MV_W-1:0];
			blm_pkg::REG_SETTLE: settle_cfg = value[blm_pkg::TICK_W-1:0];
			default: ;
		endcase
	endtask

	task automatic verify_registers();
		logic [blm_pkg::DATA_W-1:0] got;
		foreach (all_regs[i]) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= blm_pkg::ADDR_W'({all_regs[i], 2'b00});
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (pready !== 1'b1);
			got = prdata;
			psel <= 1'b0;
			penable <= 1'b0;
			if (got !== register_image(all_regs[i])) begin
				$error("register %0d: expected %0d, got %0d", all_regs[i],
					register_image(all_regs[i]), got);
				err_count++;
			end
		end
	endtask

	task automatic apply_settings(input blm_pkg::mv_t crit, input blm_pkg::mv_t low,
		input blm_pkg::mv_t over, input blm_pkg::mv_t hyst, input blm_pkg::tick_t settle);
		write_register(blm_pkg::REG_CRITICAL, blm_pkg::DATA_W'(crit));
		write_register(blm_pkg::REG_LOW, blm_pkg::DATA_W'(low));
		write_register(blm_pkg::REG_OVER, blm_pkg::DATA_W'(over));
		write_register(blm_pkg::REG_HYST, blm_pkg::DATA_W'(hyst));
		write_register(blm_pkg::REG_SETTLE, blm_pkg::DATA_W'(settle));
		verify_registers();
		settings_count++;
	endtask

	// Called at a rising edge; returns at the edge that accepts the request.
	task automatic drive_tick(input blm_pkg::mv_t v, input logic rs, input logic typed,
		input monitor_result_t typed_want);
		int unsigned gap;
		monitor_result_t pred;
		gap = pick_gap(tx_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		voltage_mv <= v;
		restart <= rs;
		do @(posedge clk); while (in_stall !== 1'b0);
		pred = advance_monitor(v, rs);
		pending_results.push_back(typed ? typed_want : pred);
		tick_count++;
		if (rs) restart_count++;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, pending_results.size());
			$display("FAIL battery_level_monitor_top");
			$finish;
		end
	end

	initial begin : result_checker
		monitor_result_t want;
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			hold = pick_gap(rx_calm);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: level %0d", level);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (level !== want.lvl) begin
					$error("level: expected %0d, got %0d", want.lvl, level);
					err_count++;
				end
				if (charger_off_request !== want.charger_off) begin
					$error("charger_off_request: expected %0b, got %0b",
						want.charger_off, charger_off_request);
					err_count++;
				end
				if (power_stage_off_request !== want.stage_off) begin
					$error("power_stage_off_request: expected %0b, got %0b",
						want.stage_off, power_stage_off_request);
					err_count++;
				end
				if (device_disabled !== want.disabled) begin
					$error("device_disabled: expected %0b, got %0b",
						want.disabled, device_disabled);
					err_count++;
				end
			end
		end
	end

	initial begin : stimulus
		monitor_result_t row_want;
		blm_pkg::mv_t a, b, c, tmp, h;
		blm_pkg::tick_t s;
		int unsigned n;
		int unsigned pick;
		logic rs;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		verify_registers();

		// A one-tick settle keeps the directed sequence short.
		apply_settings(blm_pkg::CRITICAL_RST, blm_pkg::LOW_RST, blm_pkg::OVER_RST,
			blm_pkg::HYST_RST, 8'd1);
		foreach (directed_rows[i]) begin
			row_want.lvl = directed_rows[i].lvl;
			row_want.charger_off = directed_rows[i].chg;
			row_want.stage_off = directed_rows[i].stg;
			row_want.disabled = directed_rows[i].dis;
			drive_tick(directed_rows[i].volt, directed_rows[i].rs, directed_rows[i].typed,
				row_want);
		end
		in_valid <= 1'b0;
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: apply_settings(blm_pkg::CRITICAL_RST, blm_pkg::LOW_RST, blm_pkg::OVER_RST,
					blm_pkg::HYST_RST, blm_pkg::SETTLE_RST);
				1: apply_settings('0, '0, '0, '0, '0);
				2: apply_settings('1, '1, '1, '1, '1);
				default: begin
					a = blm_pkg::mv_t'($urandom);
					b = blm_pkg::mv_t'($urandom);
					c = blm_pkg::mv_t'($urandom);
					// Most settings keep the thresholds ordered; the rest let them overlap.
					if ($urandom_range(0, 4) != 0) begin
						if (a > b) begin tmp = a; a = b; b = tmp; end
						if (b > c) begin tmp = b; b = c; c = tmp; end
						if (a > b) begin tmp = a; a = b; b = tmp; end
					end
					h = $urandom_range(0, 1) ? blm_pkg::mv_t'($urandom_range(0, 1000))
						: blm_pkg::mv_t'($urandom);
					pick = $urandom_range(0, 9);
					if (pick < 6) s = blm_pkg::tick_t'($urandom_range(0, 4));
					else if (pick < 9) s = blm_pkg::tick_t'($urandom_range(5, 40));
					else s = blm_pkg::tick_t'($urandom);
					apply_settings(a, b, c, h, s);
				end
			endcase
			n = 80 + settle_cfg;
			repeat (n) begin
				rs = ($urandom_range(0, 63 + 2 * settle_cfg) == 0);
				drive_tick(pick_voltage(), rs, 1'b0, '0);
			end
			in_valid <= 1'b0;
			wait_drained();
		end

		repeat (4) @(posedge clk);
		$display("Ran %0d ticks (%0d restarts) across %0d register settings.",
			tick_count, restart_count, settings_count);
		$display("Checked %0d results; %0d mismatches.", results_checked, err_count);
		if (err_count == 0) begin
			$display("PASS battery_level_monitor_top");
		end else begin
			$display("FAIL battery_level_monitor_top");
		end
		$finish;
	end

endmodule

[battery_level_monitor_top.f]
rtl/blm_pkg.sv
rtl/battery_level_monitor_top.sv
sim/battery_level_monitor_tb.sv
